### hdl/csh_pkg.sv
// shared types, constants and fixed-point helpers for the circle segment hit time block
package csh_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_BITS  = WORD_BITS - 1;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int TOL_BITS  = 16;
  localparam int NRM_BITS  = 18;
  localparam int CFG_IDX_BITS = 3;

  // restoring divider: input stage, one stage per quotient bit, output stage
  localparam int QUO_BITS = WORD_BITS + FRAC_BITS;
  localparam int DIV_LAT  = QUO_BITS + 2;

  // stage indices of the solver pipeline
  localparam int K1  = DIV_LAT + 1;
  localparam int K2  = K1 + 1;
  localparam int K3  = K2 + 1;
  localparam int K4  = K3 + 1;
  localparam int K5  = K4 + DIV_LAT + 1;
  localparam int K6  = K5 + 1;
  localparam int K7  = K6 + 1;
  localparam int K8  = K7 + 1;
  localparam int K9  = K8 + 1;
  localparam int K10 = K9 + DIV_LAT + 1;
  localparam int SOLVE_LAT = K10 + 1;

  typedef logic signed [WORD_BITS-1:0] fx_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  localparam fx_t FX_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam fx_t FX_ONE = fx_t'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_IDLE    = 2'd2,
    ST_UNREACH = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_NORM_X  = 3'd4,
    REG_NORM_Y  = 3'd5,
    REG_TOL     = 3'd6,
    REG_ABORT   = 3'd7
  } cfg_reg_t;

  // one queued circle item
  typedef struct packed {
    fx_t                 pos_x;
    fx_t                 pos_y;
    fx_t                 vel_x;
    fx_t                 vel_y;
    logic [RAD_BITS-1:0] radius;
    logic                idle;
    fx_t                 time_budget;
  } item_t;

  // one system's operands, axes already swapped for the y system
  typedef struct packed {
    fx_t pu;
    fx_t pv;
    fx_t vu;
    fx_t vv;
    fx_t r;
    fx_t bud;
  } sys_in_t;

  // wall setup seen by one system
  typedef struct packed {
    fx_t                 su;
    fx_t                 sv;
    fx_t                 du;
    fx_t                 dv;
    fx_t                 nu;
    fx_t                 nv;
    logic [TOL_BITS-1:0] tol;
    logic                may_abort;
  } sys_cfg_t;

  // one system's answer
  typedef struct packed {
    logic    ok;
    status_t st;
    fx_t     t;
  } sys_res_t;

  // everything that travels down the solver pipeline
  typedef struct packed {
    fx_t     pu;
    fx_t     pv;
    fx_t     vu;
    fx_t     vv;
    fx_t     r;
    fx_t     bud;
    fx_t     e;
    fx_t     svp;
    prod_t   p1;
    prod_t   p2;
    prod_t   p3;
    fx_t     a;
    fx_t     b;
    fx_t     c0;
    logic    azero;
    prod_t   pc;
    prod_t   prn;
    fx_t     bpc;
    fx_t     bmc;
    fx_t     rn;
    logic    rej;
    logic    first;
    logic    abr;
    fx_t     tk;
    prod_t   pv2;
    fx_t     s1;
    fx_t     l1;
    fx_t     l2;
    logic    ok;
    status_t st;
    fx_t     t;
  } ctx_t;

  // clamp a wide value to the word range
  function automatic fx_t fx_sat(input prod_t v);
    if (v > prod_t'(FX_MAX)) return FX_MAX;
    else if (v < prod_t'(FX_MIN)) return FX_MIN;
    else return v[WORD_BITS-1:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? FX_MIN : FX_MAX;
    else return s[WORD_BITS-1:0];
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? FX_MIN : FX_MAX;
    else return s[WORD_BITS-1:0];
  endfunction

  // product back to word format, rounded toward minus infinity
  function automatic fx_t fx_mulsh(input prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    return fx_sat(s);
  endfunction

endpackage

### hdl/csh_if.sv
// channel interfaces: circle input, result output and the internal item queue link
interface csh_in_if;
  logic                          valid;
  logic                          ready;
  csh_pkg::fx_t                  pos_x;
  csh_pkg::fx_t                  pos_y;
  csh_pkg::fx_t                  vel_x;
  csh_pkg::fx_t                  vel_y;
  logic [csh_pkg::RAD_BITS-1:0]  radius;
  logic                          idle;
  csh_pkg::fx_t                  time_budget;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, radius, idle, time_budget,
                  input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, radius, idle, time_budget,
                output ready);
endinterface

interface csh_out_if;
  logic              valid;
  logic              ready;
  csh_pkg::status_t  status;
  csh_pkg::fx_t      hit_time;
  modport source (output valid, status, hit_time, input ready);
  modport sink (input valid, status, hit_time, output ready);
endinterface

interface csh_item_if;
  logic            valid;
  logic            ready;
  csh_pkg::item_t  item;
  modport source (output valid, item, input ready);
  modport sink (input valid, item, output ready);
endinterface

### hdl/csh_front.sv
// front end: accepts circle items and queues them for the solver
module csh_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  csh_in_if.sink     in_ch,
  csh_item_if.source q_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  csh_pkg::item_t mem_r [QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push, pop;
  csh_pkg::item_t wr_item;

  // handshakes
  assign in_ch.ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign q_ch.valid  = (cnt_r != '0);
  assign q_ch.item   = mem_r[rp_r];
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_ch.valid && q_ch.ready;

  // pack the incoming item
  always_comb begin
    wr_item.pos_x       = in_ch.pos_x;
    wr_item.pos_y       = in_ch.pos_y;
    wr_item.vel_x       = in_ch.vel_x;
    wr_item.vel_y       = in_ch.vel_y;
    wr_item.radius      = in_ch.radius;
    wr_item.idle        = in_ch.idle;
    wr_item.time_budget = in_ch.time_budget;
  end

  // pointer and fill count update
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

### hdl/csh_div.sv
// pipelined restoring divider, quotient of num * 2^frac / den rounded toward zero, saturated
module csh_div (
  input  logic         clk,
  input  logic         en,
  input  csh_pkg::fx_t num,
  input  csh_pkg::fx_t den,
  output csh_pkg::fx_t quo
);

  localparam int W  = csh_pkg::WORD_BITS;
  localparam int QB = csh_pkg::QUO_BITS;

  logic [W-1:0]  rem_r [QB+1];
  logic [QB-1:0] nq_r  [QB+1];
  logic [W-1:0]  dv_r  [QB+1];
  logic          sg_r  [QB+1];
  logic [W-1:0]  rem_nxt [QB+1];
  logic          bit_nxt [QB+1];
  csh_pkg::fx_t  quo_r, quo_nxt;
  logic [W-1:0]  abs_n, abs_d;
  logic [QB-1:0] q;
  logic          ovp, ovn;

  // magnitudes of the operands
  assign abs_n = num[W-1] ? W'(-num) : W'(num);
  assign abs_d = den[W-1] ? W'(-den) : W'(den);

  // one quotient bit per stage
  always_comb begin
    logic [W:0] trial;
    rem_nxt[0] = '0;
    bit_nxt[0] = 1'b0;
    for (int k = 1; k <= QB; k++) begin
      trial = {rem_r[k-1], nq_r[k-1][QB-1]};
      bit_nxt[k] = (trial >= {1'b0, dv_r[k-1]});
      rem_nxt[k] = bit_nxt[k] ? W'(trial - {1'b0, dv_r[k-1]}) : trial[W-1:0];
    end
  end

  // sign and saturation
  always_comb begin
    q   = nq_r[QB];
    ovp = |q[QB-1:W-1];
    ovn = (|q[QB-1:W]) || (q[W-1] && (|q[W-2:0]));
    if (!sg_r[QB]) quo_nxt = ovp ? csh_pkg::FX_MAX : q[W-1:0];
    else           quo_nxt = ovn ? csh_pkg::FX_MIN : W'(-q[W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= {abs_n, {csh_pkg::FRAC_BITS{1'b0}}};
      dv_r[0]  <= abs_d;
      sg_r[0]  <= num[W-1] ^ den[W-1];
      for (int k = 1; k <= QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= {nq_r[k-1][QB-2:0], bit_nxt[k]};
        dv_r[k]  <= dv_r[k-1];
        sg_r[k]  <= sg_r[k-1];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

### hdl/csh_solve.sv
// one linear system: edge-crossing times, nearest time, contact parameter check
module csh_solve (
  input  logic              clk,
  input  logic              en,
  input  csh_pkg::sys_in_t  sin,
  input  csh_pkg::sys_cfg_t cfg,
  output csh_pkg::sys_res_t res
);

  localparam int W = csh_pkg::WORD_BITS;
  localparam int L = csh_pkg::SOLVE_LAT;

  csh_pkg::ctx_t ctx_r [L];
  csh_pkg::ctx_t stg_nxt [L];
  csh_pkg::ctx_t ld_nxt, k1_nxt, k2_nxt, k3_nxt, k4_nxt, k5_nxt;
  csh_pkg::ctx_t k6_nxt, k7_nxt, k8_nxt, k9_nxt, k10_nxt;
  csh_pkg::fx_t  q1, q2, q3, t1, t2, lq;

  // first division batch, all by the wall direction
  csh_div u_div_v (.clk(clk), .en(en), .num(ctx_r[0].vu), .den(cfg.du), .quo(q1));
  csh_div u_div_e (.clk(clk), .en(en), .num(ctx_r[0].e),  .den(cfg.du), .quo(q2));
  csh_div u_div_n (.clk(clk), .en(en), .num(cfg.nu),      .den(cfg.du), .quo(q3));

  // crossing times
  csh_div u_div_t1 (.clk(clk), .en(en), .num(ctx_r[csh_pkg::K4].bpc),
                    .den(ctx_r[csh_pkg::K4].a), .quo(t1));
  csh_div u_div_t2 (.clk(clk), .en(en), .num(ctx_r[csh_pkg::K4].bmc),
                    .den(ctx_r[csh_pkg::K4].a), .quo(t2));

  // contact parameter
  csh_div u_div_l (.clk(clk), .en(en), .num(ctx_r[csh_pkg::K9].l2), .den(cfg.du), .quo(lq));

  // load: offsets from the wall start
  always_comb begin
    ld_nxt     = '0;
    ld_nxt.pu  = sin.pu;
    ld_nxt.pv  = sin.pv;
    ld_nxt.vu  = sin.vu;
    ld_nxt.vv  = sin.vv;
    ld_nxt.r   = sin.r;
    ld_nxt.bud = sin.bud;
    ld_nxt.e   = csh_pkg::fx_sub(sin.pu, cfg.su);
    ld_nxt.svp = csh_pkg::fx_sub(cfg.sv, sin.pv);
  end

  // scale the quotients by the other direction component
  always_comb begin
    k1_nxt    = ctx_r[csh_pkg::K1-1];
    k1_nxt.p1 = q1 * cfg.dv;
    k1_nxt.p2 = q2 * cfg.dv;
    k1_nxt.p3 = q3 * cfg.dv;
  end

  // system coefficients
  always_comb begin
    k2_nxt    = ctx_r[csh_pkg::K2-1];
    k2_nxt.a  = csh_pkg::fx_sub(k2_nxt.vv, csh_pkg::fx_mulsh(k2_nxt.p1));
    k2_nxt.b  = csh_pkg::fx_add(k2_nxt.svp, csh_pkg::fx_mulsh(k2_nxt.p2));
    k2_nxt.c0 = csh_pkg::fx_sub(cfg.nv, csh_pkg::fx_mulsh(k2_nxt.p3));
  end

  // radius products
  always_comb begin
    k3_nxt       = ctx_r[csh_pkg::K3-1];
    k3_nxt.azero = (k3_nxt.a == '0);
    k3_nxt.pc    = k3_nxt.r * k3_nxt.c0;
    k3_nxt.prn   = k3_nxt.r * cfg.nu;
  end

  // numerators of both crossing times
  always_comb begin
    csh_pkg::fx_t c;
    k4_nxt     = ctx_r[csh_pkg::K4-1];
    c          = csh_pkg::fx_mulsh(k4_nxt.pc);
    k4_nxt.bpc = csh_pkg::fx_add(k4_nxt.b, c);
    k4_nxt.bmc = csh_pkg::fx_sub(k4_nxt.b, c);
    k4_nxt.rn  = csh_pkg::fx_mulsh(k4_nxt.prn);
  end

  // tolerance reject, nearest time, budget check
  always_comb begin
    logic [W:0]   s1, s2;
    csh_pkg::fx_t lim;
    k5_nxt       = ctx_r[csh_pkg::K5-1];
    s1           = (W+1)'(t1) + (W+1)'(cfg.tol);
    s2           = (W+1)'(t2) + (W+1)'(cfg.tol);
    k5_nxt.rej   = s1[W] || s2[W];
    k5_nxt.first = (t1 < t2);
    k5_nxt.tk    = k5_nxt.first ? t1 : t2;
    lim          = csh_pkg::fx_add(k5_nxt.bud, csh_pkg::fx_t'(cfg.tol));
    k5_nxt.abr   = cfg.may_abort && (k5_nxt.tk > lim);
  end

  // travel along the velocity
  always_comb begin
    k6_nxt     = ctx_r[csh_pkg::K6-1];
    k6_nxt.pv2 = k6_nxt.tk * k6_nxt.vu;
  end

  always_comb begin
    k7_nxt    = ctx_r[csh_pkg::K7-1];
    k7_nxt.s1 = csh_pkg::fx_add(k7_nxt.pu, csh_pkg::fx_mulsh(k7_nxt.pv2));
  end

  always_comb begin
    k8_nxt    = ctx_r[csh_pkg::K8-1];
    k8_nxt.l1 = csh_pkg::fx_sub(k8_nxt.s1, cfg.su);
  end

  // contact point offset by the radius along the normal
  always_comb begin
    k9_nxt    = ctx_r[csh_pkg::K9-1];
    k9_nxt.l2 = k9_nxt.first ? csh_pkg::fx_sub(k9_nxt.l1, k9_nxt.rn)
                             : csh_pkg::fx_add(k9_nxt.l1, k9_nxt.rn);
  end

  // final verdict of this system
  always_comb begin
    logic inr;
    k10_nxt    = ctx_r[csh_pkg::K10-1];
    inr        = !lq[W-1] && (lq <= csh_pkg::FX_ONE);
    k10_nxt.ok = (cfg.du != '0) && !k10_nxt.azero;
    if (k10_nxt.rej)      k10_nxt.st = csh_pkg::ST_MISS;
    else if (k10_nxt.abr) k10_nxt.st = csh_pkg::ST_UNREACH;
    else if (inr)         k10_nxt.st = csh_pkg::ST_HIT;
    else                  k10_nxt.st = csh_pkg::ST_MISS;
    k10_nxt.t  = (k10_nxt.st == csh_pkg::ST_HIT) ? k10_nxt.tk : '0;
  end

  // next contents of every stage, working stages override the plain copy
  always_comb begin
    stg_nxt[0] = ld_nxt;
    for (int k = 1; k < L; k++) stg_nxt[k] = ctx_r[k-1];
    stg_nxt[csh_pkg::K1]  = k1_nxt;
    stg_nxt[csh_pkg::K2]  = k2_nxt;
    stg_nxt[csh_pkg::K3]  = k3_nxt;
    stg_nxt[csh_pkg::K4]  = k4_nxt;
    stg_nxt[csh_pkg::K5]  = k5_nxt;
    stg_nxt[csh_pkg::K6]  = k6_nxt;
    stg_nxt[csh_pkg::K7]  = k7_nxt;
    stg_nxt[csh_pkg::K8]  = k8_nxt;
    stg_nxt[csh_pkg::K9]  = k9_nxt;
    stg_nxt[csh_pkg::K10] = k10_nxt;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L; k++) ctx_r[k] <= stg_nxt[k];
    end
  end

  assign res.ok = ctx_r[L-1].ok;
  assign res.st = ctx_r[L-1].st;
  assign res.t  = ctx_r[L-1].t;

endmodule

### hdl/csh_back.sv
// back end: runs both systems in step, picks the answer and holds it for the sink
module csh_back (
  input  logic              clk,
  input  logic              rst_n,
  input  csh_pkg::sys_cfg_t cfg_x,
  input  csh_pkg::sys_cfg_t cfg_y,
  csh_item_if.sink          q_ch,
  csh_out_if.source         out_ch
);

  localparam int L = csh_pkg::SOLVE_LAT;

  logic              en;
  logic              v_r   [L];
  logic              idl_r [L];
  logic              out_v_r;
  csh_pkg::status_t  out_st_r, out_st_nxt;
  csh_pkg::fx_t      out_t_r, out_t_nxt;
  csh_pkg::sys_in_t  sin_x, sin_y;
  csh_pkg::sys_res_t res_x, res_y;

  // whole pipeline moves while the output slot is free or being emptied
  assign en         = !out_v_r || out_ch.ready;
  assign q_ch.ready = en;

  // x system as given, y system with the axes swapped
  always_comb begin
    sin_x.pu  = q_ch.item.pos_x;
    sin_x.pv  = q_ch.item.pos_y;
    sin_x.vu  = q_ch.item.vel_x;
    sin_x.vv  = q_ch.item.vel_y;
    sin_x.r   = csh_pkg::fx_t'(q_ch.item.radius);
    sin_x.bud = q_ch.item.time_budget;
    sin_y.pu  = q_ch.item.pos_y;
    sin_y.pv  = q_ch.item.pos_x;
    sin_y.vu  = q_ch.item.vel_y;
    sin_y.vv  = q_ch.item.vel_x;
    sin_y.r   = csh_pkg::fx_t'(q_ch.item.radius);
    sin_y.bud = q_ch.item.time_budget;
  end

  csh_solve u_solve_x (.clk(clk), .en(en), .sin(sin_x), .cfg(cfg_x), .res(res_x));
  csh_solve u_solve_y (.clk(clk), .en(en), .sin(sin_y), .cfg(cfg_y), .res(res_y));

  // valid bits alongside the solvers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_ch.valid;
      for (int k = 1; k < L; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idl_r[0] <= q_ch.item.idle;
      for (int k = 1; k < L; k++) idl_r[k] <= idl_r[k-1];
      out_st_r <= out_st_nxt;
      out_t_r  <= out_t_nxt;
    end
  end

  // idle first, then the x system, then the y system
  always_comb begin
    if (idl_r[L-1]) begin
      out_st_nxt = csh_pkg::ST_IDLE;
      out_t_nxt  = csh_pkg::FX_MAX;
    end else if (res_x.ok) begin
      out_st_nxt = res_x.st;
      out_t_nxt  = res_x.t;
    end else if (res_y.ok) begin
      out_st_nxt = res_y.st;
      out_t_nxt  = res_y.t;
    end else begin
      out_st_nxt = csh_pkg::ST_MISS;
      out_t_nxt  = '0;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.status   = out_st_r;
  assign out_ch.hit_time = out_t_r;

endmodule

### hdl/circle_segment_hit_time.sv
// Swept circle against wall segment: time of first contact. An accepted item goes
// through the queue, the solver stages and the output register; the solver depth is set
// by three 50-stage restoring dividers in series in each system.
// Throughput: one item per cycle while the output is not stalled; both systems run side
// by side in one stall domain.
// Reset: synchronous active-low rst_n clears queue, valid bits and wall registers
// (tolerance to 66); no clearing pass.
module circle_segment_hit_time #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  csh_in_if.sink                             in_ch,
  csh_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [csh_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [csh_pkg::WORD_BITS-1:0]      cfg_data
);

  csh_pkg::fx_t                          start_x_r, start_y_r, dir_x_r, dir_y_r;
  logic signed [csh_pkg::NRM_BITS-1:0]   norm_x_r, norm_y_r;
  logic [csh_pkg::TOL_BITS-1:0]          tol_r;
  logic                                  abort_r;
  csh_pkg::sys_cfg_t                     cfg_x, cfg_y;

  csh_item_if q_ch ();

  // wall registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      dir_x_r   <= '0;
      dir_y_r   <= '0;
      norm_x_r  <= '0;
      norm_y_r  <= '0;
      tol_r     <= csh_pkg::TOL_BITS'(66);
      abort_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (csh_pkg::cfg_reg_t'(cfg_idx))
        csh_pkg::REG_START_X: start_x_r <= cfg_data;
        csh_pkg::REG_START_Y: start_y_r <= cfg_data;
        csh_pkg::REG_DIR_X:   dir_x_r   <= cfg_data;
        csh_pkg::REG_DIR_Y:   dir_y_r   <= cfg_data;
        csh_pkg::REG_NORM_X:  norm_x_r  <= cfg_data[csh_pkg::NRM_BITS-1:0];
        csh_pkg::REG_NORM_Y:  norm_y_r  <= cfg_data[csh_pkg::NRM_BITS-1:0];
        csh_pkg::REG_TOL:     tol_r     <= cfg_data[csh_pkg::TOL_BITS-1:0];
        csh_pkg::REG_ABORT:   abort_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // wall as seen by each system, abort only in the x system
  always_comb begin
    cfg_x.su        = start_x_r;
    cfg_x.sv        = start_y_r;
    cfg_x.du        = dir_x_r;
    cfg_x.dv        = dir_y_r;
    cfg_x.nu        = csh_pkg::fx_t'(norm_x_r);
    cfg_x.nv        = csh_pkg::fx_t'(norm_y_r);
    cfg_x.tol       = tol_r;
    cfg_x.may_abort = abort_r;
    cfg_y.su        = start_y_r;
    cfg_y.sv        = start_x_r;
    cfg_y.du        = dir_y_r;
    cfg_y.dv        = dir_x_r;
    cfg_y.nu        = csh_pkg::fx_t'(norm_y_r);
    cfg_y.nv        = csh_pkg::fx_t'(norm_x_r);
    cfg_y.tol       = tol_r;
    cfg_y.may_abort = 1'b0;
  end

  csh_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_ch(q_ch)
  );

  csh_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_x(cfg_x), .cfg_y(cfg_y), .q_ch(q_ch), .out_ch(out_ch)
  );

  // idle items report the largest time
  a_idle_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == csh_pkg::ST_IDLE) |-> out_ch.hit_time == csh_pkg::FX_MAX)
    else $error("idle item without maximum time");

  // misses and unreachable hits carry a zero time
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == csh_pkg::ST_MISS ||
                      out_ch.status == csh_pkg::ST_UNREACH)) |-> out_ch.hit_time == '0)
    else $error("non-hit item with non-zero time");

  // queued item stays at the head until the solver takes it
  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_ch.valid && !q_ch.ready) |=> q_ch.valid)
    else $error("queued item lost while stalled");

endmodule

### sim/circle_segment_hit_time_tb.sv
// testbench for the swept circle against wall segment hit time block
module circle_segment_hit_time_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_LIMIT = 5000;
  localparam int  DRAIN_CYCLES   = 200;
  localparam int  RANDOM_PER_SET = 100;
  localparam longint Q_ONE       = 64'sd65536;
  localparam longint W_MAX       = 64'sd2147483647;
  localparam longint W_MIN       = -64'sd2147483648;

  typedef struct {
    csh_pkg::status_t st;
    csh_pkg::fx_t     t;
  } hit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  csh_pkg::cfg_reg_t cfg_idx;
  logic [csh_pkg::WORD_BITS-1:0] cfg_data;

  csh_in_if  in_ch();
  csh_out_if out_ch();

  circle_segment_hit_time dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // wall setup as the block should hold it
  longint wsx, wsy, wdx, wdy, wnx, wny, wtol, wabort;

  csh_pkg::item_t circles_pending[$];
  hit_t   hits_expected[$];
  int     circles_sent;
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     quiet_cycles;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // fixed-point arithmetic with saturation
  function automatic longint fx_clamp(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return fx_clamp(p >>> csh_pkg::FRAC_BITS);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    if (d == 0) return 0;
    return fx_clamp((n * Q_ONE) / d);
  endfunction

  // one linear system; returns 0 when it is degenerate
  function automatic bit solve_system(longint pu, longint pv, longint vu, longint vv,
                                      longint su, longint sv, longint du, longint dv,
                                      longint nu, longint nv, longint r, longint budget,
                                      bit may_abort, output csh_pkg::status_t st,
                                      output longint t);
    longint a, b, c, t1, t2, tk, l, rn;
    bit first;
    st = csh_pkg::ST_MISS;
    t  = 0;
    if (du == 0) return 0;
    a = fx_clamp(vv - fx_mul(fx_div(vu, du), dv));
    if (a == 0) return 0;
    b = fx_clamp(fx_clamp(sv - pv) + fx_mul(fx_div(fx_clamp(pu - su), du), dv));
    c = fx_mul(r, fx_clamp(nv - fx_mul(fx_div(nu, du), dv)));
    t1 = fx_div(fx_clamp(b + c), a);
    if (t1 < -wtol) return 1;
    t2 = fx_div(fx_clamp(b - c), a);
    if (t2 < -wtol) return 1;
    first = t1 < t2;
    tk = first ? t1 : t2;
    if (may_abort && tk > fx_clamp(budget + wtol)) begin
      st = csh_pkg::ST_UNREACH;
      return 1;
    end
    rn = fx_mul(r, nu);
    l = fx_clamp(fx_clamp(pu + fx_mul(tk, vu)) - su);
    l = first ? fx_clamp(l - rn) : fx_clamp(l + rn);
    l = fx_div(l, du);
    if (l >= 0 && l <= Q_ONE) begin
      st = csh_pkg::ST_HIT;
      t  = tk;
    end
    return 1;
  endfunction

  // first contact of one circle with the current wall
  function automatic hit_t predict_hit(csh_pkg::item_t c);
    hit_t   h;
    longint t;
    csh_pkg::status_t st;
    longint px, py, vx, vy, r, bud;
    px  = c.pos_x;
    py  = c.pos_y;
    vx  = c.vel_x;
    vy  = c.vel_y;
    r   = longint'({1'b0, c.radius});
    bud = c.time_budget;
    if (c.idle) begin
      h.st = csh_pkg::ST_IDLE;
      h.t  = csh_pkg::FX_MAX;
      return h;
    end
    if (!solve_system(px, py, vx, vy, wsx, wsy, wdx, wdy, wnx, wny, r, bud,
                      wabort != 0, st, t)) begin
      if (!solve_system(py, px, vy, vx, wsy, wsx, wdy, wdx, wny, wnx, r, bud,
                        1'b0, st, t)) begin
        st = csh_pkg::ST_MISS;
        t  = 0;
      end
    end
    h.st = st;
    h.t  = csh_pkg::fx_t'(t);
    return h;
  endfunction

  function automatic csh_pkg::item_t circle(longint px, longint py, longint vx, longint vy,
                                            longint r, bit idle, longint bud);
    csh_pkg::item_t c;
    c.pos_x       = csh_pkg::fx_t'(px);
    c.pos_y       = csh_pkg::fx_t'(py);
    c.vel_x       = csh_pkg::fx_t'(vx);
    c.vel_y       = csh_pkg::fx_t'(vy);
    c.radius      = r[csh_pkg::RAD_BITS-1:0];
    c.idle        = idle;
    c.time_budget = csh_pkg::fx_t'(bud);
    return c;
  endfunction

  function automatic longint spread(longint range);
    return longint'($urandom_range(32'(2 * range))) - range;
  endfunction

  function automatic longint corner_value();
    case ($urandom_range(4))
      0: return W_MIN;
      1: return W_MAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // random circle, mostly aimed at the wall
  function automatic csh_pkg::item_t random_circle();
    longint px, py, vx, vy, sp, span, f;
    int     kind;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      f    = $urandom_range(120);
      span = $urandom_range(20 * 65536);
      sp   = $urandom_range(16 * 65536);
      px = fx_clamp(wsx + (wdx / 100) * (f - 10) + ((wnx * span) >>> 16) + spread(Q_ONE));
      py = fx_clamp(wsy + (wdy / 100) * (f - 10) + ((wny * span) >>> 16) + spread(Q_ONE));
      vx = fx_clamp(-((wnx * sp) >>> 16) + spread(2 * Q_ONE));
      vy = fx_clamp(-((wny * sp) >>> 16) + spread(2 * Q_ONE));
      return circle(px, py, vx, vy, $urandom_range(3 * 65536), $urandom_range(19) == 0,
                    spread(16 * Q_ONE) + 4 * Q_ONE);
    end
    if (kind == 7)
      return circle(spread(64 * Q_ONE), spread(64 * Q_ONE), spread(16 * Q_ONE),
                    spread(16 * Q_ONE), $urandom_range(8 * 65536), $urandom_range(1),
                    spread(32 * Q_ONE));
    if (kind == 8)
      return circle(longint'(int'($urandom)), longint'(int'($urandom)),
                    longint'(int'($urandom)), longint'(int'($urandom)),
                    longint'($urandom & 32'h7fff_ffff), $urandom_range(1),
                    longint'(int'($urandom)));
    return circle(corner_value(), corner_value(), corner_value(), corner_value(),
                  corner_value() & W_MAX, $urandom_range(1), corner_value());
  endfunction

  // register write, only while nothing is in flight
  task automatic write_reg(csh_pkg::cfg_reg_t idx, longint value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[csh_pkg::WORD_BITS-1:0];
    case (idx)
      csh_pkg::REG_START_X: wsx = longint'(signed'(value[31:0]));
      csh_pkg::REG_START_Y: wsy = longint'(signed'(value[31:0]));
      csh_pkg::REG_DIR_X:   wdx = longint'(signed'(value[31:0]));
      csh_pkg::REG_DIR_Y:   wdy = longint'(signed'(value[31:0]));
      csh_pkg::REG_NORM_X:  wnx = longint'(signed'(value[17:0]));
      csh_pkg::REG_NORM_Y:  wny = longint'(signed'(value[17:0]));
      csh_pkg::REG_TOL:     wtol = longint'(value[15:0]);
      default:              wabort = longint'(value[0]);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_wall(longint sx, longint sy, longint dx, longint dy,
                          longint nx, longint ny, longint tol, longint abort_on);
    write_reg(csh_pkg::REG_START_X, sx);
    write_reg(csh_pkg::REG_START_Y, sy);
    write_reg(csh_pkg::REG_DIR_X, dx);
    write_reg(csh_pkg::REG_DIR_Y, dy);
    write_reg(csh_pkg::REG_NORM_X, nx);
    write_reg(csh_pkg::REG_NORM_Y, ny);
    write_reg(csh_pkg::REG_TOL, tol);
    write_reg(csh_pkg::REG_ABORT, abort_on);
  endtask

  task automatic queue_random(int n);
    repeat (n) circles_pending.push_back(random_circle());
  endtask

  task automatic wait_drained();
    wait (circles_pending.size() == 0 && hits_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.radius = '0;
    in_ch.idle = 1'b0;
    in_ch.time_budget = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = csh_pkg::REG_START_X;
    cfg_data = '0;
    circles_sent = 0;
    mismatches = 0;
    send_idle_pct = 12;
    recv_idle_pct = 68;
    wsx = 0; wsy = 0; wdx = 0; wdy = 0; wnx = 0; wny = 0; wtol = 66; wabort = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: zero-length wall never hits
    queue_random(30);
    wait_drained();

    // horizontal wall along x from 0 to 10, normal up, abort on
    set_wall(0, 0, 10 * Q_ONE, 0, 0, Q_ONE, 66, 1);
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0, 100 * Q_ONE));
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 1, 100 * Q_ONE));
    // moving away: negative times
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, Q_ONE, Q_ONE, 0, 100 * Q_ONE));
    // still circle: both systems degenerate
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, 0, Q_ONE, 0, 100 * Q_ONE));
    // passes beyond the end of the wall
    circles_pending.push_back(circle(20 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0, 100 * Q_ONE));
    // contact exactly at both ends
    circles_pending.push_back(circle(0, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0, 100 * Q_ONE));
    circles_pending.push_back(circle(10 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0, 100 * Q_ONE));
    // beyond the time budget, and right at budget plus tolerance
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0, Q_ONE));
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0,
                                     4 * Q_ONE - 66));
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -Q_ONE, Q_ONE, 0,
                                     4 * Q_ONE - 67));
    // already touching: slightly negative time inside and outside tolerance
    circles_pending.push_back(circle(5 * Q_ONE, Q_ONE - 50, 0, -Q_ONE, Q_ONE, 0, Q_ONE));
    circles_pending.push_back(circle(5 * Q_ONE, Q_ONE - 100, 0, -Q_ONE, Q_ONE, 0, Q_ONE));
    // very slow circle: time saturates
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, 0, -1, Q_ONE, 0, W_MAX));
    circles_pending.push_back(circle(5 * Q_ONE, 5 * Q_ONE, Q_ONE, -Q_ONE, 0, 0, W_MIN));
    // field extremes
    circles_pending.push_back(circle(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0, W_MAX));
    circles_pending.push_back(circle(W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, W_MIN));
    circles_pending.push_back(circle(W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, 0, 0));
    circles_pending.push_back(circle(-1, -1, -1, -1, W_MAX, 1, -1));
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // vertical wall: only the y system applies
    set_wall(-5 * Q_ONE, -5 * Q_ONE, 0, 10 * Q_ONE, -Q_ONE, 0, 0, 1);
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // diagonal wall, widest tolerance
    set_wall(2 * Q_ONE, 3 * Q_ONE, 8 * Q_ONE, 6 * Q_ONE, -39322, 52429, 65535, 1);
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // register extremes
    set_wall(W_MAX, W_MIN, W_MIN, W_MAX, 65536, -65536, 0, 1);
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // diagonal wall, no abort
    set_wall(Q_ONE, -Q_ONE, -4 * Q_ONE, 4 * Q_ONE, -46341, -46341, 1000, 0);
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // normal not of unit length
    set_wall(-3 * Q_ONE, 7 * Q_ONE, 3 * Q_ONE, -7 * Q_ONE, 65536, 30000, 66, 1);
    queue_random(RANDOM_PER_SET);
    wait_drained();

    if (mismatches == 0) begin
      $display("circle_segment_hit_time_tb passed");
    end else begin
      $display("circle_segment_hit_time_tb failed");
    end
    $finish;
  end

  // idling pattern follows progress through the stimulus
  always @(posedge clk) begin
    if (circles_sent < 230) begin
      send_idle_pct <= 12;
      recv_idle_pct <= 68;
    end else if (circles_sent < 460) begin
      send_idle_pct <= 68;
      recv_idle_pct <= 12;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // circle driver
  always @(posedge clk) begin
    bit go;
    csh_pkg::item_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      go = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        hits_expected.push_back(predict_hit(circles_pending[0]));
        circles_pending.pop_front();
        circles_sent++;
      end else if (in_ch.valid) begin
        go = 1'b1;
      end
      if (!go)
        go = circles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct;
      in_ch.valid <= go;
      if (go) begin
        c = circles_pending[0];
        in_ch.pos_x       <= c.pos_x;
        in_ch.pos_y       <= c.pos_y;
        in_ch.vel_x       <= c.vel_x;
        in_ch.vel_y       <= c.vel_y;
        in_ch.radius      <= c.radius;
        in_ch.idle        <= c.idle;
        in_ch.time_budget <= c.time_budget;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    hit_t h;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hits_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: status %0d hit_time %0d", out_ch.status,
                     out_ch.hit_time);
        end else begin
          h = hits_expected.pop_front();
          if (out_ch.status !== h.st || out_ch.hit_time !== h.t) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status exp %0d got %0d, hit_time exp %0d got %0d",
                       h.st, out_ch.status, h.t, out_ch.hit_time);
          end
        end
      end
      out_ch.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (circles_pending.size() == 0 && hits_expected.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("circle_segment_hit_time_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### circle_segment_hit_time.f
hdl/csh_pkg.sv
hdl/csh_if.sv
hdl/csh_front.sv
hdl/csh_div.sv
hdl/csh_solve.sv
hdl/csh_back.sv
hdl/circle_segment_hit_time.sv
sim/circle_segment_hit_time_tb.sv
